[rtl/mpie_pkg.sv]
// Shared types, codes and constants of the MIPS pseudo-instruction execute block.
package mpie_pkg;

  localparam int MEM_BYTES_DEF   = 4096;
  localparam int MAX_PROGRAM_DEF = 1024;
  localparam int PC_SPAN         = 1024;
  localparam logic [10:0] LEN_RESET = 11'd1024;

  // Opcodes
  localparam logic [5:0] OP_LW    = 6'd0;
  localparam logic [5:0] OP_LH    = 6'd1;
  localparam logic [5:0] OP_LB    = 6'd2;
  localparam logic [5:0] OP_LA    = 6'd3;
  localparam logic [5:0] OP_LI    = 6'd4;
  localparam logic [5:0] OP_SW    = 6'd5;
  localparam logic [5:0] OP_SH    = 6'd6;
  localparam logic [5:0] OP_SB    = 6'd7;
  localparam logic [5:0] OP_MOVE  = 6'd8;
  localparam logic [5:0] OP_MFHI  = 6'd9;
  localparam logic [5:0] OP_MFLO  = 6'd10;
  localparam logic [5:0] OP_MTHI  = 6'd11;
  localparam logic [5:0] OP_MTLO  = 6'd12;
  localparam logic [5:0] OP_ADD   = 6'd13;
  localparam logic [5:0] OP_SUB   = 6'd14;
  localparam logic [5:0] OP_MULT  = 6'd15;
  localparam logic [5:0] OP_DIV   = 6'd16;
  localparam logic [5:0] OP_MULO  = 6'd17;
  localparam logic [5:0] OP_MUL   = 6'd18;
  localparam logic [5:0] OP_ADDU  = 6'd19;
  localparam logic [5:0] OP_SUBU  = 6'd20;
  localparam logic [5:0] OP_MULTU = 6'd21;
  localparam logic [5:0] OP_DIVU  = 6'd22;
  localparam logic [5:0] OP_MULOU = 6'd23;
  localparam logic [5:0] OP_REM   = 6'd24;
  localparam logic [5:0] OP_NEG   = 6'd25;
  localparam logic [5:0] OP_ABS   = 6'd26;
  localparam logic [5:0] OP_REMU  = 6'd27;
  localparam logic [5:0] OP_NEGU  = 6'd28;
  localparam logic [5:0] OP_AND   = 6'd29;
  localparam logic [5:0] OP_NOR   = 6'd30;
  localparam logic [5:0] OP_NOT   = 6'd31;
  localparam logic [5:0] OP_XOR   = 6'd32;
  localparam logic [5:0] OP_OR    = 6'd33;
  localparam logic [5:0] OP_J     = 6'd34;
  localparam logic [5:0] OP_BEQ   = 6'd35;
  localparam logic [5:0] OP_BNE   = 6'd36;
  localparam logic [5:0] OP_BLT   = 6'd37;
  localparam logic [5:0] OP_BLE   = 6'd38;
  localparam logic [5:0] OP_BGT   = 6'd39;
  localparam logic [5:0] OP_BGE   = 6'd40;
  localparam logic [5:0] OP_NOP   = 6'd41;
  // Highest unused opcode; every unused opcode acts as a nop
  localparam logic [5:0] OP_SPARE = 6'd63;

  // Operand kinds
  localparam logic [1:0] KIND_REG = 2'd0;
  localparam logic [1:0] KIND_IMM = 2'd1;
  localparam logic [1:0] KIND_MEM = 2'd2;
  // Spare kind, acts as a register operand
  localparam logic [1:0] KIND_ALT = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_MEM  = 3'd1;
  localparam logic [2:0] ST_OVF  = 3'd2;
  localparam logic [2:0] ST_DIVZ = 3'd3;
  localparam logic [2:0] ST_PC   = 3'd4;

  typedef struct packed {
    logic [5:0]         opcode;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg;
    logic [4:0]         src2_reg;
    logic [1:0]         operand_kind;
    logic signed [31:0] immediate;
    logic signed [15:0] offset;
    logic [9:0]         target;
  } mpie_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       branch_taken;
    logic [9:0] next_pc;
  } mpie_out_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_ADDR, S_MRD, S_MRDW, S_MWR,
    S_OPER, S_MUL, S_DIVS, S_DIV, S_WB
  } state_t;

  typedef struct packed {
    logic clr;
    logic cap;
    logic rd;
    logic addr;
    logic mrd;
    logic mcap;
    logic mwr;
    logic oper;
    logic mul;
    logic dstart;
    logic wb;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_rd;
    logic need_wr;
    logic oob;
    logic last_byte;
    logic is_mul;
    logic is_div;
    logic div_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

[rtl/mpie_div.sv]
// Radix-2 restoring divider, signed or unsigned, one quotient bit per cycle.
module mpie_div import mpie_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        sgn,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] den_r, den_nxt;
  logic        negq_r, negq_nxt;
  logic        negr_r, negr_nxt;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        a_neg, b_neg;

  assign a_neg   = sgn & dividend[31];
  assign b_neg   = sgn & divisor[31];
  assign shifted = {rem_r, quo_r[31]};
  assign diff    = shifted - {1'b0, den_r};

  // Load magnitudes on start, then shift and subtract
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    negq_nxt = negq_r;
    negr_nxt = negr_r;
    if (start) begin
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      quo_nxt  = a_neg ? 32'(-dividend) : dividend;
      den_nxt  = b_neg ? 32'(-divisor) : divisor;
      negq_nxt = a_neg ^ b_neg;
      negr_nxt = a_neg;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    negq_r <= negq_nxt;
    negr_r <= negr_nxt;
  end

  // Apply signs to the magnitudes
  assign done      = done_r;
  assign quotient  = negq_r ? 32'(-quo_r) : quo_r;
  assign remainder = negr_r ? 32'(-rem_r) : rem_r;

endmodule

[rtl/mpie_dp.sv]
// Datapath: register file, hi/lo, pc, byte memory, multiplier, divider, result register.
module mpie_dp import mpie_pkg::*; #(
  parameter int MEM_BYTES   = MEM_BYTES_DEF,
  parameter int MAX_PROGRAM = MAX_PROGRAM_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  mpie_in_t  in_data,
  input  logic      cfg_valid,
  input  logic [10:0] cfg_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_valid,
  input  logic      out_stall,
  output mpie_out_t out_data
);

  localparam int AW   = $clog2(MEM_BYTES);
  localparam int PLIM = (MAX_PROGRAM < PC_SPAN) ? MAX_PROGRAM : PC_SPAN;

  mpie_in_t    item_r;
  logic [10:0] len_r;
  logic [31:0] rf [32];
  logic [31:0] rf_vld_r;
  logic [31:0] ra_r, rb_r, b_r, word_r, hi_r, lo_r;
  logic [33:0] ea_r;
  logic [2:0]  n_r;
  logic [1:0]  cnt_r;
  logic        oob_r;
  logic [63:0] prod_r;
  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  mrd_r;
  logic [AW-1:0] clr_r;
  logic [9:0]  pc_r;
  mpie_out_t   out_r;
  logic        out_valid_r;

  // Decode
  logic [5:0] op;
  logic is_load, is_store, is_ls, is_unary, is_bin, is_br, k_imm, k_mem, uses_fetch;
  logic portb_d;
  logic [4:0] rb_addr;
  logic [2:0] n_nxt;
  logic [33:0] imm34, ra34, off34, base34, ea_nxt, lim34;
  logic oob_nxt;
  logic [AW-1:0] maddr;
  logic [31:0] b_nxt;

  assign op         = item_r.opcode;
  assign is_load    = op <= OP_LB;
  assign is_ls      = op <= OP_SB;
  assign is_store   = op >= OP_SW && op <= OP_SB;
  assign is_unary   = op == OP_NEG || op == OP_ABS || op == OP_NEGU || op == OP_NOT;
  assign is_bin     = op >= OP_ADD && op <= OP_OR && !is_unary;
  assign is_br      = op >= OP_BEQ && op <= OP_BGE;
  assign k_imm      = item_r.operand_kind == KIND_IMM;
  assign k_mem      = item_r.operand_kind == KIND_MEM;
  assign uses_fetch = (is_unary || is_bin || is_br) && k_mem;
  assign portb_d    = is_store || op == OP_MTHI || op == OP_MTLO || is_br;
  assign rb_addr    = portb_d ? item_r.dest_reg : item_r.src2_reg;

  // Effective address and bounds
  always_comb begin
    if (uses_fetch || op == OP_LW || op == OP_SW) n_nxt = 3'd4;
    else if (op == OP_LH || op == OP_SH)          n_nxt = 3'd2;
    else                                          n_nxt = 3'd1;
  end

  assign imm34  = {{2{item_r.immediate[31]}}, item_r.immediate};
  assign ra34   = {{2{ra_r[31]}}, ra_r};
  assign off34  = {{18{item_r.offset[15]}}, item_r.offset};
  assign base34 = (k_imm || k_mem) ? imm34 : ra34;
  assign ea_nxt = uses_fetch ? imm34 : base34 + off34;
  assign lim34  = 34'(MEM_BYTES) - {31'b0, n_nxt};
  assign oob_nxt = ea_nxt[33] || (ea_nxt > lim34);
  assign maddr  = ea_r[AW-1:0] + AW'(cnt_r);

  // Second operand
  always_comb begin
    if (k_imm)                   b_nxt = item_r.immediate;
    else if (k_mem)              b_nxt = word_r;
    else if (is_unary || is_br)  b_nxt = ra_r;
    else                         b_nxt = rb_r;
  end

  // Multiplier operands
  logic mul_sgn;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod_full;
  assign mul_sgn   = op == OP_MULT || op == OP_MULO;
  assign ma        = {mul_sgn & ra_r[31], ra_r};
  assign mb        = {mul_sgn & b_r[31], b_r};
  assign prod_full = ma * mb;

  // Divider
  logic        div_done;
  logic [31:0] quo, rmd;
  mpie_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.dstart),
    .sgn(op == OP_DIV || op == OP_REM),
    .dividend(ra_r), .divisor(b_r),
    .done(div_done), .quotient(quo), .remainder(rmd)
  );

  // Program length and sequential advance
  logic [10:0] len_cap, len_eff, pc_inc;
  logic [9:0]  seq_next;
  assign len_cap  = (len_r > 11'(PLIM)) ? 11'(PLIM) : len_r;
  assign len_eff  = (len_cap == 11'd0) ? 11'd1 : len_cap;
  assign pc_inc   = {1'b0, pc_r} + 11'd1;
  assign seq_next = (pc_inc >= len_eff) ? 10'd0 : pc_inc[9:0];

  // Result, status and next pc of the item
  logic [31:0] res, hi_v, lo_v, sum, dif;
  logic wr_d, wr_hi, wr_lo, cond, taken;
  logic [2:0] st;
  logic [9:0] nxt;
  logic signed [31:0] xs, ys;

  assign sum = ra_r + b_r;
  assign dif = ra_r - b_r;
  assign xs  = rb_r;
  assign ys  = b_r;

  always_comb begin
    res   = '0;
    hi_v  = prod_r[63:32];
    lo_v  = prod_r[31:0];
    wr_d  = 1'b0;
    wr_hi = 1'b0;
    wr_lo = 1'b0;
    cond  = 1'b0;
    st    = ST_OK;
    case (op)
      OP_LW, OP_LH, OP_LB: begin res = word_r; wr_d = 1'b1; end
      OP_LA:   begin res = ea_r[31:0]; wr_d = 1'b1; end
      OP_LI:   begin res = item_r.immediate; wr_d = 1'b1; end
      OP_MOVE: begin res = ra_r; wr_d = 1'b1; end
      OP_MFHI: begin res = hi_r; wr_d = 1'b1; end
      OP_MFLO: begin res = lo_r; wr_d = 1'b1; end
      OP_MTHI: begin hi_v = rb_r; wr_hi = 1'b1; end
      OP_MTLO: begin lo_v = rb_r; wr_lo = 1'b1; end
      OP_NEG: begin
        res = 32'(-b_r); wr_d = 1'b1;
        if (b_r == 32'h8000_0000) st = ST_OVF;
      end
      OP_ABS: begin
        res = b_r[31] ? 32'(-b_r) : b_r; wr_d = 1'b1;
        if (b_r == 32'h8000_0000) st = ST_OVF;
      end
      OP_NEGU: begin res = 32'(-b_r); wr_d = 1'b1; end
      OP_NOT:  begin res = ~b_r; wr_d = 1'b1; end
      OP_ADD: begin
        res = sum; wr_d = 1'b1;
        if (ra_r[31] == b_r[31] && sum[31] != ra_r[31]) st = ST_OVF;
      end
      OP_SUB: begin
        res = dif; wr_d = 1'b1;
        if (ra_r[31] != b_r[31] && dif[31] != ra_r[31]) st = ST_OVF;
      end
      OP_MULT, OP_MULTU: begin wr_hi = 1'b1; wr_lo = 1'b1; end
      OP_MULO: begin
        res = prod_r[31:0]; wr_d = 1'b1;
        if (prod_r[63:31] != {33{1'b0}} && prod_r[63:31] != {33{1'b1}}) st = ST_OVF;
      end
      OP_MUL, OP_MULOU: begin res = prod_r[31:0]; wr_d = 1'b1; end
      OP_DIV, OP_DIVU: begin
        hi_v = rmd; lo_v = quo; wr_hi = 1'b1; wr_lo = 1'b1;
        if (b_r == '0) st = ST_DIVZ;
      end
      OP_REM, OP_REMU: begin
        res = rmd; wr_d = 1'b1;
        if (b_r == '0) st = ST_DIVZ;
      end
      OP_ADDU: begin res = sum; wr_d = 1'b1; end
      OP_SUBU: begin res = dif; wr_d = 1'b1; end
      OP_AND:  begin res = ra_r & b_r; wr_d = 1'b1; end
      OP_NOR:  begin res = ~(ra_r | b_r); wr_d = 1'b1; end
      OP_XOR:  begin res = ra_r ^ b_r; wr_d = 1'b1; end
      OP_OR:   begin res = ra_r | b_r; wr_d = 1'b1; end
      OP_J:    cond = 1'b1;
      OP_BEQ:  cond = xs == ys;
      OP_BNE:  cond = xs != ys;
      OP_BLT:  cond = xs < ys;
      OP_BLE:  cond = xs <= ys;
      OP_BGT:  cond = xs > ys;
      OP_BGE:  cond = xs >= ys;
      default: ;
    endcase
    if (oob_r) st = ST_MEM;
    nxt   = seq_next;
    taken = 1'b0;
    if (st == ST_OK && cond) begin
      if ({1'b0, item_r.target} >= len_eff) st = ST_PC;
      else begin
        nxt   = item_r.target;
        taken = 1'b1;
      end
    end
    if (st != ST_OK) begin
      nxt   = pc_r;
      taken = 1'b0;
    end
  end

  logic commit;
  assign commit = cmd.wb && st == ST_OK;

  // Item capture and operand staging
  always_ff @(posedge clk) begin
    if (cmd.cap) item_r <= in_data;
    if (cmd.rd) begin
      ra_r <= rf_vld_r[item_r.src_reg] ? rf[item_r.src_reg] : '0;
      rb_r <= rf_vld_r[rb_addr] ? rf[rb_addr] : '0;
    end
    if (cmd.addr) begin
      ea_r   <= ea_nxt;
      n_r    <= n_nxt;
      oob_r  <= oob_nxt && (is_ls && !(op == OP_LA || op == OP_LI) || uses_fetch);
      word_r <= '0;
      cnt_r  <= '0;
    end
    if (cmd.mcap) begin
      word_r[8*cnt_r +: 8] <= mrd_r;
      cnt_r <= cnt_r + 2'd1;
    end
    if (cmd.mwr) cnt_r <= cnt_r + 2'd1;
    if (cmd.oper) b_r <= b_nxt;
    if (cmd.mul) prod_r <= prod_full[63:0];
  end

  // Register file, entries read as zero until written
  always_ff @(posedge clk) begin
    if (commit && wr_d && item_r.dest_reg != 5'd0) rf[item_r.dest_reg] <= res;
  end

  // Byte memory: clear sweep, store bytes, registered read
  always_ff @(posedge clk) begin
    if (cmd.clr) mem[clr_r] <= '0;
    else if (cmd.mwr) mem[maddr] <= rb_r[8*cnt_r +: 8];
    if (cmd.mrd) mrd_r <= mem[maddr];
  end

  // Control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LEN_RESET;
      rf_vld_r    <= '0;
      hi_r        <= '0;
      lo_r        <= '0;
      pc_r        <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) len_r <= cfg_data;
      if (cmd.clr) clr_r <= clr_r + AW'(1);
      if (commit) begin
        if (wr_d && item_r.dest_reg != 5'd0) rf_vld_r[item_r.dest_reg] <= 1'b1;
        if (wr_hi) hi_r <= hi_v;
        if (wr_lo) lo_r <= lo_v;
      end
      if (cmd.wb) begin
        if (st == ST_OK) pc_r <= nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      out_r.status       <= st;
      out_r.branch_taken <= taken;
      out_r.next_pc      <= nxt;
    end
  end

  // Status to the controller
  assign sts.clr_last  = clr_r == AW'(MEM_BYTES - 1);
  assign sts.need_rd   = is_load || uses_fetch;
  assign sts.need_wr   = is_store;
  assign sts.oob       = oob_nxt && (is_load || is_store || uses_fetch);
  assign sts.last_byte = cnt_r == 2'(n_r - 3'd1);
  assign sts.is_mul    = op == OP_MULT || op == OP_MULTU || op == OP_MULO ||
                         op == OP_MUL || op == OP_MULOU;
  assign sts.is_div    = op == OP_DIV || op == OP_DIVU || op == OP_REM || op == OP_REMU;
  assign sts.div_zero  = b_r == '0;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/mpie_ctrl.sv]
// Controller state machine that sequences each item through the datapath.
module mpie_ctrl import mpie_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_READ;
      S_READ:  state_nxt = S_ADDR;
      S_ADDR: begin
        if (sts.oob)          state_nxt = S_WB;
        else if (sts.need_rd) state_nxt = S_MRD;
        else if (sts.need_wr) state_nxt = S_MWR;
        else                  state_nxt = S_OPER;
      end
      S_MRD:  state_nxt = S_MRDW;
      S_MRDW: state_nxt = sts.last_byte ? S_OPER : S_MRD;
      S_MWR:  if (sts.last_byte) state_nxt = S_WB;
      S_OPER: begin
        if (sts.is_mul)      state_nxt = S_MUL;
        else if (sts.is_div) state_nxt = S_DIVS;
        else                 state_nxt = S_WB;
      end
      S_MUL:  state_nxt = S_WB;
      S_DIVS: state_nxt = sts.div_zero ? S_WB : S_DIV;
      S_DIV:  if (sts.div_done) state_nxt = S_WB;
      S_WB:   if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    case (state_r)
      S_CLEAR: cmd.clr    = 1'b1;
      S_IDLE:  cmd.cap    = in_valid;
      S_READ:  cmd.rd     = 1'b1;
      S_ADDR:  cmd.addr   = 1'b1;
      S_MRD:   cmd.mrd    = 1'b1;
      S_MRDW:  cmd.mcap   = 1'b1;
      S_MWR:   cmd.mwr    = 1'b1;
      S_OPER:  cmd.oper   = 1'b1;
      S_MUL:   cmd.mul    = 1'b1;
      S_DIVS:  cmd.dstart = !sts.div_zero;
      S_WB:    cmd.wb     = sts.out_free;
      default: ;
    endcase
  end

  assign in_stall = state_r != S_IDLE;

endmodule

[rtl/mips_pseudo_instruction_execute.sv]
// Top level of the MIPS pseudo-instruction execute block.
// Executes one decoded instruction per item and returns status, branch flag and next pc.
// After reset the block sweeps its byte memory to zero, one byte per cycle, and accepts
// no item until the sweep is done (MEM_BYTES bytes, 4096 by default). An item then passes
// through register read, address and operand steps to write-back; multiplies add one
// 33x33 multiplier stage, loads and memory operands read one byte at a time (single-port
// byte memory with registered read), stores write their bytes and skip the operand stage,
// and divide and remainder run the 32-step radix-2 divider unless the divisor is zero.
// A stalled result holds the write-back step of the next item; the result waits
// in an output register, so a new item is taken while it is still stalled.
// program_length may be written at any time the block is idle.
module mips_pseudo_instruction_execute import mpie_pkg::*; #(
  parameter int MEM_BYTES   = MEM_BYTES_DEF,
  parameter int MAX_PROGRAM = MAX_PROGRAM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  mpie_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output mpie_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mpie_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  mpie_dp #(.MEM_BYTES(MEM_BYTES), .MAX_PROGRAM(MAX_PROGRAM)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

[test/mips_pseudo_instruction_execute_tb.sv]
// Testbench for the MIPS pseudo-instruction execute block: directed table, random items, scoreboard.
`timescale 1ns / 100ps

module mips_pseudo_instruction_execute_tb;
  import mpie_pkg::*;

  localparam int MEMSZ      = 4096;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 60;
  localparam int PHASE_INSTRS = 238;

  typedef struct {
    mpie_in_t  instr;
    bit        fixed;
    mpie_out_t want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  mpie_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  mpie_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [10:0] cfg_data = '0;

  // Shadow architectural state
  logic [31:0] gpr [32];
  logic [31:0] hi_q, lo_q;
  logic [9:0]  pc_q;
  logic [7:0]  dmem [MEMSZ];
  logic [10:0] prog_len;

  row_t      rows[$];
  mpie_out_t result_q[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;
  int  ostall_left = 0;

  mips_pseudo_instruction_execute u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint sx(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic bit fits(longint v);
    return v >= -64'sd2147483648 && v <= 64'sd2147483647;
  endfunction

  function automatic bit in_range(longint a, int n);
    return a >= 0 && a + n <= MEMSZ;
  endfunction

  function automatic void wreg(logic [4:0] r, logic [31:0] v);
    if (r != 0) gpr[r] = v;
  endfunction

  // Fetch the second operand; returns 0 on an out-of-range memory word
  function automatic bit fetch_operand(logic [1:0] kind, logic [4:0] r,
                                       logic [31:0] imm, output logic [31:0] v);
    longint a;
    v = '0;
    if (kind == KIND_IMM) begin
      v = imm;
      return 1'b1;
    end
    if (kind == KIND_MEM) begin
      a = sx(imm);
      if (!in_range(a, 4)) return 1'b0;
      for (int i = 3; i >= 0; i--) v = {v[23:0], dmem[a + i]};
      return 1'b1;
    end
    v = gpr[r];
    return 1'b1;
  endfunction

  // Execute one instruction on the shadow state and return its expected result
  function automatic mpie_out_t execute_instr(mpie_in_t it);
    mpie_out_t res;
    logic [31:0] a, b, w;
    longint sa, sb, base, addr, r, x;
    longint unsigned up;
    int len, n;
    logic [9:0] nxt;
    logic [2:0] st;
    bit taken, cond;
    len = (prog_len > 1024) ? 1024 : (prog_len == 0) ? 1 : int'(prog_len);
    nxt = (int'(pc_q) + 1 >= len) ? 10'd0 : pc_q + 10'd1;
    st = ST_OK;
    taken = 0;
    cond = 0;
    a = gpr[it.src_reg];
    sa = sx(a);
    b = '0;
    w = '0;
    if (it.opcode <= OP_SB) begin
      base = (it.operand_kind == KIND_IMM || it.operand_kind == KIND_MEM) ?
             sx(it.immediate) : sa;
      addr = base + longint'(it.offset);
      n = (it.opcode == OP_LW || it.opcode == OP_SW) ? 4 :
          (it.opcode == OP_LH || it.opcode == OP_SH) ? 2 : 1;
      if (it.opcode == OP_LA) wreg(it.dest_reg, addr[31:0]);
      else if (it.opcode == OP_LI) wreg(it.dest_reg, it.immediate);
      else if (!in_range(addr, n)) st = ST_MEM;
      else if (it.opcode <= OP_LB) begin
        for (int i = n - 1; i >= 0; i--) w = {w[23:0], dmem[addr + i]};
        wreg(it.dest_reg, w);
      end else begin
        w = gpr[it.dest_reg];
        for (int i = 0; i < n; i++) dmem[addr + i] = w[8*i +: 8];
      end
    end else begin
      case (it.opcode)
        OP_MOVE: wreg(it.dest_reg, a);
        OP_MFHI: wreg(it.dest_reg, hi_q);
        OP_MFLO: wreg(it.dest_reg, lo_q);
        OP_MTHI: hi_q = gpr[it.dest_reg];
        OP_MTLO: lo_q = gpr[it.dest_reg];
        OP_NEG, OP_ABS, OP_NEGU, OP_NOT: begin
          if (!fetch_operand(it.operand_kind, it.src_reg, it.immediate, b)) st = ST_MEM;
          else if (it.opcode == OP_NOT) wreg(it.dest_reg, ~b);
          else if (it.opcode == OP_NEGU) wreg(it.dest_reg, 32'd0 - b);
          else begin
            sb = sx(b);
            r = (it.opcode == OP_NEG || sb < 0) ? -sb : sb;
            if (!fits(r)) st = ST_OVF;
            else wreg(it.dest_reg, r[31:0]);
          end
        end
        OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_MULO, OP_MUL, OP_ADDU, OP_SUBU,
        OP_MULTU, OP_DIVU, OP_MULOU, OP_REM, OP_REMU, OP_AND, OP_NOR, OP_XOR,
        OP_OR: begin
          if (!fetch_operand(it.operand_kind, it.src2_reg, it.immediate, b)) st = ST_MEM;
          else begin
            sb = sx(b);
            case (it.opcode)
              OP_ADD, OP_SUB: begin
                r = (it.opcode == OP_ADD) ? sa + sb : sa - sb;
                if (!fits(r)) st = ST_OVF;
                else wreg(it.dest_reg, r[31:0]);
              end
              OP_MULT: begin
                r = sa * sb;
                hi_q = r[63:32];
                lo_q = r[31:0];
              end
              OP_DIV, OP_REM: begin
                if (b == 0) st = ST_DIVZ;
                else if (it.opcode == OP_DIV) begin
                  r = sa / sb;
                  lo_q = r[31:0];
                  r = sa % sb;
                  hi_q = r[31:0];
                end else begin
                  r = sa % sb;
                  wreg(it.dest_reg, r[31:0]);
                end
              end
              OP_MULO: begin
                r = sa * sb;
                if (!fits(r)) st = ST_OVF;
                else wreg(it.dest_reg, r[31:0]);
              end
              OP_MUL, OP_MULOU: begin
                w = a * b;
                wreg(it.dest_reg, w);
              end
              OP_ADDU: wreg(it.dest_reg, a + b);
              OP_SUBU: wreg(it.dest_reg, a - b);
              OP_MULTU: begin
                up = {32'd0, a} * {32'd0, b};
                hi_q = up[63:32];
                lo_q = up[31:0];
              end
              OP_DIVU, OP_REMU: begin
                if (b == 0) st = ST_DIVZ;
                else if (it.opcode == OP_DIVU) begin
                  lo_q = a / b;
                  hi_q = a % b;
                end else wreg(it.dest_reg, a % b);
              end
              OP_AND: wreg(it.dest_reg, a & b);
              OP_NOR: wreg(it.dest_reg, ~(a | b));
              OP_XOR: wreg(it.dest_reg, a ^ b);
              default: wreg(it.dest_reg, a | b);
            endcase
          end
        end
        OP_J, OP_BEQ, OP_BNE, OP_BLT, OP_BLE, OP_BGT, OP_BGE: begin
          if (it.opcode == OP_J) cond = 1;
          else if (!fetch_operand(it.operand_kind, it.src_reg, it.immediate, b)) st = ST_MEM;
          else begin
            x = sx(gpr[it.dest_reg]);
            sb = sx(b);
            case (it.opcode)
              OP_BEQ:  cond = x == sb;
              OP_BNE:  cond = x != sb;
              OP_BLT:  cond = x < sb;
              OP_BLE:  cond = x <= sb;
              OP_BGT:  cond = x > sb;
              default: cond = x >= sb;
            endcase
          end
          if (st == ST_OK && cond) begin
            if (int'(it.target) >= len) st = ST_PC;
            else begin
              nxt = it.target;
              taken = 1;
            end
          end
        end
        default: ;
      endcase
    end
    // A failing instruction leaves the pc in place
    if (st != ST_OK) begin
      nxt = pc_q;
      taken = 0;
    end else pc_q = nxt;
    res.status = st;
    res.branch_taken = taken;
    res.next_pc = nxt;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic mpie_in_t mk(logic [5:0] op, int d, int s, int s2,
                                  logic [1:0] kind, logic [31:0] imm,
                                  int off, int tgt);
    mpie_in_t it;
    it.opcode = op; it.dest_reg = 5'(d); it.src_reg = 5'(s); it.src2_reg = 5'(s2);
    it.operand_kind = kind; it.immediate = imm; it.offset = 16'(off);
    it.target = 10'(tgt);
    return it;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(mpie_in_t it, bit fixed, mpie_out_t want);
    row_t rw;
    rw.instr = it;
    rw.fixed = fixed;
    rw.want = want;
    rows.insert(rows.size(), rw);
  endfunction

  // Mostly well-formed items with addresses near memory and valid targets; some raw noise
  function automatic mpie_in_t random_instr();
    mpie_in_t it;
    logic [95:0] raw;
    int r;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(mpie_in_t)-1:0];
    r = $urandom_range(99);
    if (r < 8) return it;
    if (r < 22) begin
      it.opcode = OP_LI;
      case ($urandom_range(3))
        0: it.immediate = $urandom_range(0, 20);
        1: it.immediate = -$urandom_range(0, 20);
        2: it.immediate = $urandom_range(0, MEMSZ - 4);
        default: it.immediate = $urandom;
      endcase
      return it;
    end
    it.opcode = 6'($urandom_range(0, int'(OP_NOP)));
    it.operand_kind = ($urandom_range(9) == 0) ? KIND_ALT : 2'($urandom_range(0, 2));
    if (it.opcode <= OP_SB || it.operand_kind == KIND_MEM) begin
      if ($urandom_range(9) != 0) begin
        it.immediate = $urandom_range(0, MEMSZ + 8);
        it.offset = 16'($urandom_range(0, 16) - 8);
        if (it.opcode <= OP_SB && it.operand_kind != KIND_MEM && $urandom_range(1))
          it.operand_kind = KIND_IMM;
      end
    end else if (it.operand_kind == KIND_IMM && $urandom_range(1))
      it.immediate = $urandom_range(0, 8) - 4;
    if (it.opcode >= OP_J && $urandom_range(7) != 0)
      it.target = 10'($urandom_range(0, (prog_len == 0) ? 0 :
                  ((prog_len > 1024) ? 1023 : prog_len - 1)));
    return it;
  endfunction

  // Offer one item and record its expected result once taken
  task automatic send_instr(mpie_in_t it, bit fixed, mpie_out_t want);
    int g;
    mpie_out_t res;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    res = execute_instr(it);
    result_q.insert(result_q.size(), fixed ? want : res);
  endtask

  // Drain, settle, then write the program length
  task automatic write_length(logic [10:0] v);
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    prog_len = v;
  endtask

  // Random stall on the result side
  always @(posedge clk) begin
    if (ostall_left > 0) begin
      ostall_left <= ostall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      ostall_left <= pick_gap();
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    mpie_out_t want;
    if (out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = result_q.pop_front();
        if (out_data.status !== want.status || out_data.branch_taken !== want.branch_taken
            || out_data.next_pc !== want.next_pc) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d taken %0d pc %0d, got %0d %0d %0d",
                     want.status, want.branch_taken, want.next_pc,
                     out_data.status, out_data.branch_taken, out_data.next_pc);
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    logic [10:0] lengths[5];
    int left;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    for (int i = 0; i < MEMSZ; i++) dmem[i] = '0;
    hi_q = '0;
    lo_q = '0;
    pc_q = '0;
    prog_len = LEN_RESET;
    lengths = '{11'd2047, 11'd1, 11'd37, 11'd0, 11'd1024};

    // Directed table; fixed rows carry expectations read straight off the spec
    add_row(mk(OP_NOP, 0, 0, 0, KIND_REG, 0, 0, 0), 1'b1, '{ST_OK, 1'b0, 10'd1});
    add_row(mk(OP_LI, 1, 0, 0, KIND_REG, 32'h7fffffff, 0, 0), 1'b1,
            '{ST_OK, 1'b0, 10'd2});
    add_row(mk(OP_LI, 2, 0, 0, KIND_REG, 32'h80000000, 0, 0), 1'b1,
            '{ST_OK, 1'b0, 10'd3});
    add_row(mk(OP_ADD, 3, 1, 0, KIND_IMM, 1, 0, 0), 1'b1, '{ST_OVF, 1'b0, 10'd3});
    add_row(mk(OP_DIV, 3, 1, 0, KIND_IMM, 0, 0, 0), 1'b1, '{ST_DIVZ, 1'b0, 10'd3});
    add_row(mk(OP_LW, 3, 0, 0, KIND_IMM, 4093, 0, 0), 1'b1, '{ST_MEM, 1'b0, 10'd3});
    add_row(mk(OP_J, 0, 0, 0, KIND_REG, 0, 0, 1023), 1'b1, '{ST_OK, 1'b1, 10'd1023});
    add_row(mk(OP_SPARE, 31, 31, 31, KIND_ALT, 32'hffffffff, -1, 1023), 1'b1,
            '{ST_OK, 1'b0, 10'd0});
    add_row(mk(OP_LI, 6, 0, 0, KIND_REG, 32'hffffffff, 0, 0), 1'b0, '0);
    add_row(mk(OP_SW, 2, 0, 0, KIND_IMM, 4092, 0, 0), 1'b0, '0);
    add_row(mk(OP_SH, 1, 0, 0, KIND_IMM, 10, -32768, 0), 1'b0, '0);
    add_row(mk(OP_SB, 6, 0, 0, KIND_IMM, 32'h7fff, -32768, 0), 1'b0, '0);
    add_row(mk(OP_LW, 7, 0, 0, KIND_REG, 0, 4092, 0), 1'b0, '0);
    add_row(mk(OP_LH, 8, 0, 0, KIND_IMM, 4094, 0, 0), 1'b0, '0);
    add_row(mk(OP_LB, 9, 0, 0, KIND_MEM, 32767, -32768, 0), 1'b0, '0);
    add_row(mk(OP_LA, 10, 2, 0, KIND_REG, 0, 32767, 0), 1'b0, '0);
    add_row(mk(OP_DIV, 0, 2, 6, KIND_REG, 0, 0, 0), 1'b0, '0);
    add_row(mk(OP_MFLO, 11, 0, 0, KIND_REG, 0, 0, 0), 1'b0, '0);
    add_row(mk(OP_MULT, 0, 2, 1, KIND_REG, 0, 0, 0), 1'b0, '0);
    add_row(mk(OP_MFHI, 12, 0, 0, KIND_REG, 0, 0, 0), 1'b0, '0);
    add_row(mk(OP_MULO, 13, 1, 0, KIND_IMM, 2, 0, 0), 1'b0, '0);
    add_row(mk(OP_NEG, 14, 2, 0, KIND_REG, 0, 0, 0), 1'b0, '0);
    add_row(mk(OP_ABS, 15, 0, 0, KIND_MEM, 4092, 0, 0), 1'b0, '0);
    add_row(mk(OP_BLT, 2, 1, 0, KIND_REG, 0, 0, 5), 1'b0, '0);
    add_row(mk(OP_BGE, 1, 0, 0, KIND_IMM, 0, 0, 1023), 1'b0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_instr(rows[i].instr, rows[i].fixed, rows[i].want);

    // Random phases across program lengths, one without any idling
    for (int p = 0; p <= 5; p++) begin
      if (p > 0) write_length(lengths[p - 1]);
      calm = (p == 2);
      left = PHASE_INSTRS;
      while (left > 0) begin
        send_instr(random_instr(), 1'b0, '0);
        left--;
      end
    end

    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
